[rtl/bid_pkg.sv]
// shared types, constants and helpers of the button intent decoder
// no dependencies; compiled first

package bid_pkg;

  // time arithmetic width and input field widths
  localparam int unsigned TimeBitsDef = 32;
  localparam int unsigned PinBits     = 7;
  localparam int unsigned NowBits     = 32;
  localparam int unsigned CfgBits     = 16;
  localparam int unsigned CfgIdxBits  = 3;

  // register reset values, in milliseconds
  localparam logic [CfgBits-1:0] LongPressRst  = 16'd800;
  localparam logic [CfgBits-1:0] ScrollDlyRst  = 16'd400;
  localparam logic [CfgBits-1:0] ScrollFastRst = 16'd100;
  localparam logic [CfgBits-1:0] ScrollSlowRst = 16'd300;
  localparam logic [CfgBits-1:0] FastAfterRst  = 16'd800;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegLongPress  = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegScrollDly  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegScrollFast = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegScrollSlow = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegFastAfter  = 3'd4;

  // button bit positions (pins are active low)
  localparam int unsigned BtnLeft   = 0;
  localparam int unsigned BtnUp     = 1;
  localparam int unsigned BtnRight  = 2;
  localparam int unsigned BtnCentre = 3;
  localparam int unsigned BtnDown   = 4;
  localparam int unsigned BtnBack   = 5;
  localparam int unsigned BtnMenu   = 6;

  localparam logic [PinBits-1:0] AllReleased = 7'h7F;

  typedef enum logic [3:0] {
    NAV_NONE   = 4'd0,
    NAV_UP     = 4'd1,
    NAV_DOWN   = 4'd2,
    NAV_LEFT   = 4'd3,
    NAV_RIGHT  = 4'd4,
    NAV_SELECT = 4'd5,
    NAV_LONG   = 4'd6,
    NAV_BACK   = 4'd7,
    NAV_MENU   = 4'd8
  } intent_e;

  // live configuration
  typedef struct packed {
    logic [CfgBits-1:0] hold_long_ms;
    logic [CfgBits-1:0] scroll_delay_ms;
    logic [CfgBits-1:0] scroll_fast_ms;
    logic [CfgBits-1:0] scroll_slow_ms;
    logic [CfgBits-1:0] fast_after_ms;
  } cfg_t;

  // short press intent, fixed priority over the held set
  function automatic intent_e short_intent(input logic [PinBits-1:0] held);
    intent_e res;
    res = NAV_NONE;
    if (held[BtnUp])          res = NAV_UP;
    else if (held[BtnDown])   res = NAV_DOWN;
    else if (held[BtnLeft])   res = NAV_LEFT;
    else if (held[BtnRight])  res = NAV_RIGHT;
    else if (held[BtnCentre]) res = NAV_SELECT;
    else if (held[BtnBack])   res = NAV_BACK;
    else if (held[BtnMenu])   res = NAV_MENU;
    return res;
  endfunction

endpackage

[rtl/bid_if.sv]
// valid/ready channels of the button intent decoder
// depends on bid_pkg

interface bid_in_if;
  logic                          valid;
  logic                          ready;
  logic [bid_pkg::PinBits-1:0]   pins;
  logic [bid_pkg::NowBits-1:0]   now_ms;

  modport source (output valid, output pins, output now_ms, input ready);
  modport sink   (input valid, input pins, input now_ms, output ready);
endinterface

interface bid_out_if;
  logic             valid;
  logic             ready;
  bid_pkg::intent_e intent;

  modport source (output valid, output intent, input ready);
  modport sink   (input valid, input intent, output ready);
endinterface

[rtl/bid_cfg_regs.sv]
// configuration register file: five 16-bit timing registers
// depends on bid_pkg

module bid_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bid_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [bid_pkg::CfgBits-1:0]     cfg_data_i,
  output bid_pkg::cfg_t                   cfg_o
);
  import bid_pkg::*;

  cfg_t cfg_q, cfg_d;

  // decode the write, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLongPress:  cfg_d.hold_long_ms    = cfg_data_i;
        RegScrollDly:  cfg_d.scroll_delay_ms = cfg_data_i;
        RegScrollFast: cfg_d.scroll_fast_ms  = cfg_data_i;
        RegScrollSlow: cfg_d.scroll_slow_ms  = cfg_data_i;
        RegFastAfter:  cfg_d.fast_after_ms   = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_long_ms    <= LongPressRst;
      cfg_q.scroll_delay_ms <= ScrollDlyRst;
      cfg_q.scroll_fast_ms  <= ScrollFastRst;
      cfg_q.scroll_slow_ms  <= ScrollSlowRst;
      cfg_q.fast_after_ms   <= FastAfterRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/bid_core.sv]
// press tracking state and intent decision for one button sample
// depends on bid_pkg

module bid_core #(
  parameter int unsigned TIME_BITS = bid_pkg::TimeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [bid_pkg::PinBits-1:0]   pins_i,
  input  logic [bid_pkg::NowBits-1:0]   now_ms_i,
  input  bid_pkg::cfg_t                 cfg_i,
  output bid_pkg::intent_e              intent_o
);
  import bid_pkg::*;

  localparam int unsigned NowKeep = (TIME_BITS < NowBits) ? TIME_BITS : NowBits;

  logic [PinBits-1:0]   prev_q, held_q, held_d;
  logic [TIME_BITS-1:0] press_q, press_d, last_q, last_d;
  logic                 long_q, long_d;

  logic [TIME_BITS-1:0] now_t, held_for, since_rep, interval;
  logic [PinBits-1:0]   pressed, released, held_w;
  logic                 new_press, long_w, long_fire, rep_arm, rep_fire;
  intent_e              intent;

  // timestamp taken modulo the time width
  assign now_t = TIME_BITS'(now_ms_i[NowKeep-1:0]);

  // edges against the previous sample
  assign pressed   = ~pins_i & prev_q;
  assign released  = pins_i & ~prev_q;
  assign new_press = (|pressed) && (held_q == '0);

  // state as seen after a possible new press
  assign held_w    = new_press ? pressed : held_q;
  assign press_d   = new_press ? now_t : press_q;
  assign long_w    = new_press ? 1'b0 : long_q;
  assign held_for  = now_t - press_d;
  assign since_rep = now_t - (new_press ? '0 : last_q);

  // long press fires once per hold
  assign long_fire = (|held_w) && !long_w &&
                     (held_for > TIME_BITS'(cfg_i.hold_long_ms));
  assign long_d    = long_w | long_fire;

  // up/down auto repeat, slow then fast interval
  assign interval  = (held_for > TIME_BITS'(cfg_i.fast_after_ms)) ?
                     TIME_BITS'(cfg_i.scroll_fast_ms) : TIME_BITS'(cfg_i.scroll_slow_ms);
  assign rep_arm   = !long_d && (held_w[BtnUp] || held_w[BtnDown]) &&
                     (held_for > TIME_BITS'(cfg_i.scroll_delay_ms));
  assign rep_fire  = rep_arm && (since_rep > interval);
  assign last_d    = rep_fire ? now_t : (new_press ? '0 : last_q);

  // intent selection, release overrides repeat
  always_comb begin
    intent = NAV_NONE;
    held_d = held_w;
    if (long_fire && held_w[BtnCentre]) begin
      intent = NAV_LONG;
    end
    if (rep_fire) begin
      intent = held_w[BtnDown] ? NAV_DOWN : NAV_UP;
    end
    if (|(released & held_w)) begin
      if (!long_d) begin
        intent = short_intent(held_w);
      end
      held_d = '0;
    end
  end

  assign intent_o = intent;

  // state update on each item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= AllReleased;
      held_q  <= '0;
      press_q <= '0;
      long_q  <= 1'b0;
      last_q  <= '0;
    end else if (fire_i) begin
      prev_q  <= pins_i;
      held_q  <= held_d;
      press_q <= press_d;
      long_q  <= long_d;
      last_q  <= last_d;
    end
  end

endmodule

[rtl/button_intent_decoder.sv]
// top level of the button intent decoder: input and result registers
// depends on bid_pkg, bid_if, bid_cfg_regs and bid_core

// One button sample enters per clock cycle while the input register can take
// it: the sample is captured in an input register, decoded against the
// press state in one pass of logic, and the intent is held in a result
// register until taken. Every sample gives exactly one intent (none is code 0).
// The path that sets the clock is the TIME_BITS-wide timestamp subtraction and
// its compare against a 16-bit timing register. A stall on the result side
// holds an item waiting in the input register and then drops input ready in
// the same cycle; an empty input register still takes one more item. Users
// write timing registers only while no item is in flight; it is not enforced.

module button_intent_decoder #(
  parameter int unsigned TIME_BITS = bid_pkg::TimeBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bid_in_if.sink                          in_i,
  bid_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [bid_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [bid_pkg::CfgBits-1:0]     cfg_data_i
);
  import bid_pkg::*;

  cfg_t               cfg;
  logic               s1_valid_q;
  logic [PinBits-1:0] s1_pins_q;
  logic [NowBits-1:0] s1_now_q;
  logic               out_valid_q;
  intent_e            out_intent_q;
  intent_e            intent;
  logic               advance, fire, take;

  // pipeline flow control
  assign advance    = !out_valid_q || out_o.ready;
  assign fire       = s1_valid_q && advance;
  assign take       = in_i.valid && in_i.ready;
  assign in_i.ready = !s1_valid_q || advance;

  bid_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bid_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .pins_i   (s1_pins_q),
    .now_ms_i (s1_now_q),
    .cfg_i    (cfg),
    .intent_o (intent)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_pins_q <= in_i.pins;
      s1_now_q  <= in_i.now_ms;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_intent_q <= intent;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.intent = out_intent_q;

endmodule

[rtl/bid_checker.sv]
// port-level checks of the button intent decoder, bound to the top level
// depends on bid_pkg and button_intent_decoder

module bid_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [3:0]              out_intent_i
);
  import bid_pkg::*;

  // a stalled result holds its intent
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_intent_i)))
    else $error("stalled intent changed or dropped");

  // an item taken and then met by out ready gives a valid result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 out_ready_i |=> out_valid_i)
    else $error("accepted item gave no result");

  // a result never appears without an item taken earlier into the input register
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without accepted item");

  // intent code stays within the defined set
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_intent_i <= 4'(NAV_MENU)))
    else $error("undefined intent code");

endmodule

bind button_intent_decoder bid_checker u_bid_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_intent_i (out_o.intent)
);
